@@ design/cpc_pkg.sv @@
`timescale 1ns / 1ps
package cpc_pkg;

   localparam int COORD_BITS  = 12;
   localparam int MAX_POINTS  = 4096;
   localparam int CNT_BITS    = $clog2(MAX_POINTS) + 1;
   localparam int SUM_BITS    = COORD_BITS + $clog2(MAX_POINTS);
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;
   localparam int JOIN_BITS   = 26;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = JOIN_BITS;
   localparam int STEP_BITS   = $clog2(SUM_BITS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_ADDR_BITS-1:0] CSR_JOIN_DIST = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_SIZE  = 1'd1;

   // one closed cluster on its way to the divider
   typedef struct packed {
      logic [SUM_BITS-1:0] sum_x;
      logic [SUM_BITS-1:0] sum_y;
      logic [CNT_BITS-1:0] count;
      logic                overflow;
      logic                hull_done;
      logic                run_last;
   } job_type;

endpackage

@@ design/cpc_ifs.sv @@
`timescale 1ns / 1ps
interface cpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [cpc_pkg::COORD_BITS-1:0] point_x;
   logic [cpc_pkg::COORD_BITS-1:0] point_y;
   logic                           first_point;
   logic                           last_point;
   modport source (output valid, point_x, point_y, first_point, last_point, input ready);
   modport sink   (input valid, point_x, point_y, first_point, last_point, output ready);
endinterface

interface cpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cpc_pkg::COORD_BITS-1:0] center_x;
   logic [cpc_pkg::COORD_BITS-1:0] center_y;
   logic [cpc_pkg::CNT_BITS-1:0]   member_count;
   logic                           count_overflow;
   logic                           hull_done;
   logic                           run_last;
   modport source (output valid, center_x, center_y, member_count, count_overflow,
                   hull_done, run_last, input ready);
   modport sink   (input valid, center_x, center_y, member_count, count_overflow,
                   hull_done, run_last, output ready);
endinterface

interface cpc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cpc_pkg::CSR_ADDR_BITS-1:0] addr;
   logic [cpc_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

@@ design/cpc_front.sv @@
`timescale 1ns / 1ps
module cpc_front (
   input  logic             clock,
   input  logic             reset,
   cpc_req_if.sink          req_bus,
   cpc_csr_if.sink          csr_bus,
   output logic             push_valid,
   input  logic             push_ready,
   output cpc_pkg::job_type push_job
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIST = 2'd1;
   localparam logic [1:0] F_EVAL = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [cpc_pkg::COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic                           first_ff, first_in, last_ff, last_in;
   logic [cpc_pkg::SQ_BITS-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;

   logic [cpc_pkg::COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [cpc_pkg::SUM_BITS-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [cpc_pkg::CNT_BITS-1:0]   total_ff, total_in;
   logic                           ovf_ff, ovf_in, open_ff, open_in;

   logic [cpc_pkg::JOIN_BITS-1:0]  join_ff, join_in;
   logic [cpc_pkg::CNT_BITS-1:0]   min_ff, min_in;

   cpc_pkg::job_type job_a_ff, job_a_in, job_b_ff, job_b_in;
   logic             emit_a_ff, emit_a_in, emit_b_ff, emit_b_in;

   logic [cpc_pkg::COORD_BITS-1:0] dx, dy;
   logic [cpc_pkg::DIST_BITS-1:0]  dist_sq;
   logic                           joined;

   assign req_bus.ready = (state_ff == F_IDLE);
   assign csr_bus.ready = 1'b1;
   assign push_valid    = (state_ff == F_PUSH) && (emit_a_ff || emit_b_ff);
   assign push_job      = emit_a_ff ? job_a_ff : job_b_ff;

   assign dx      = (x_ff > prev_x_ff) ? x_ff - prev_x_ff : prev_x_ff - x_ff;
   assign dy      = (y_ff > prev_y_ff) ? y_ff - prev_y_ff : prev_y_ff - y_ff;
   assign dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign joined  = open_ff && !first_ff &&
                    ({{(cpc_pkg::JOIN_BITS-cpc_pkg::DIST_BITS){1'b0}}, dist_sq} < join_ff);

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      sqx_in    = dx * dx;
      sqy_in    = dy * dy;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      total_in  = total_ff;
      ovf_in    = ovf_ff;
      open_in   = open_ff;
      join_in   = join_ff;
      min_in    = min_ff;
      job_a_in  = job_a_ff;
      job_b_in  = job_b_ff;
      emit_a_in = emit_a_ff;
      emit_b_in = emit_b_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            cpc_pkg::CSR_JOIN_DIST: join_in = csr_bus.data;
            cpc_pkg::CSR_MIN_SIZE:  min_in  = csr_bus.data[cpc_pkg::CNT_BITS-1:0];
         endcase
      end

      unique case (state_ff)
         F_IDLE: begin
            if (req_bus.valid) begin
               x_in     = req_bus.point_x;
               y_in     = req_bus.point_y;
               first_in = req_bus.first_point;
               last_in  = req_bus.last_point;
               state_in = F_DIST;
            end
         end
         F_DIST: begin
            state_in = F_EVAL;
         end
         F_EVAL: begin
            // cluster closed by a break or a fresh start
            job_a_in.sum_x     = sum_x_ff;
            job_a_in.sum_y     = sum_y_ff;
            job_a_in.count     = total_ff;
            job_a_in.overflow  = ovf_ff;
            job_a_in.hull_done = 1'b0;
            emit_a_in          = open_ff && !joined && (total_ff >= min_ff);

            if (joined) begin
               if (total_ff >= cpc_pkg::CNT_BITS'(cpc_pkg::MAX_POINTS)) begin
                  ovf_in = 1'b1;
               end else begin
                  sum_x_in = sum_x_ff + cpc_pkg::SUM_BITS'(x_ff);
                  sum_y_in = sum_y_ff + cpc_pkg::SUM_BITS'(y_ff);
                  total_in = total_ff + 1'b1;
               end
            end else begin
               sum_x_in = cpc_pkg::SUM_BITS'(x_ff);
               sum_y_in = cpc_pkg::SUM_BITS'(y_ff);
               total_in = cpc_pkg::CNT_BITS'(1);
               ovf_in   = 1'b0;
            end
            prev_x_in = x_ff;
            prev_y_in = y_ff;
            open_in   = !last_ff;

            // cluster closed by the hull's last point
            job_b_in.sum_x     = sum_x_in;
            job_b_in.sum_y     = sum_y_in;
            job_b_in.count     = total_in;
            job_b_in.overflow  = ovf_in;
            job_b_in.hull_done = 1'b1;
            job_b_in.run_last  = 1'b1;
            emit_b_in          = last_ff && (total_in >= min_ff);
            job_a_in.run_last  = !emit_b_in;
            state_in           = F_PUSH;
         end
         F_PUSH: begin
            if (!emit_a_ff && !emit_b_ff) begin
               state_in = F_IDLE;
            end else if (push_ready) begin
               if (emit_a_ff) begin
                  emit_a_in = 1'b0;
               end else begin
                  emit_b_in = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         total_ff  <= '0;
         ovf_ff    <= 1'b0;
         open_ff   <= 1'b0;
         join_ff   <= '0;
         min_ff    <= cpc_pkg::CNT_BITS'(1);
         emit_a_ff <= 1'b0;
         emit_b_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         total_ff  <= total_in;
         ovf_ff    <= ovf_in;
         open_ff   <= open_in;
         join_ff   <= join_in;
         min_ff    <= min_in;
         emit_a_ff <= emit_a_in;
         emit_b_ff <= emit_b_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      job_a_ff <= job_a_in;
      job_b_ff <= job_b_in;
   end

endmodule

@@ design/cpc_queue.sv @@
`timescale 1ns / 1ps
module cpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cpc_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cpc_pkg::job_type pop_job
);

   cpc_pkg::job_type slot_ff [cpc_pkg::QUEUE_DEPTH];

   logic [cpc_pkg::QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [cpc_pkg::QPTR_BITS:0]   fill_ff, fill_in;
   logic                          do_push, do_pop;

   assign push_ready = (fill_ff != cpc_pkg::QUEUE_DEPTH[cpc_pkg::QPTR_BITS:0]);
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in   = wr_ff + cpc_pkg::QPTR_BITS'(do_push);
      rd_in   = rd_ff + cpc_pkg::QPTR_BITS'(do_pop);
      fill_in = fill_ff + (cpc_pkg::QPTR_BITS+1)'(do_push) - (cpc_pkg::QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

@@ design/cpc_back.sv @@
`timescale 1ns / 1ps
module cpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  cpc_pkg::job_type pop_job,
   cpc_rsp_if.source        rsp_bus
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_OUT  = 2'd2;

   // one restoring step: {remainder, quotient bit}
   function automatic logic [cpc_pkg::CNT_BITS:0] div_step(
      input logic [cpc_pkg::CNT_BITS-1:0] rem,
      input logic                         bit_in,
      input logic [cpc_pkg::CNT_BITS-1:0] den
   );
      logic [cpc_pkg::CNT_BITS:0] t;
      logic [cpc_pkg::CNT_BITS:0] d;
      t = {rem, bit_in};
      d = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
         div_step = {d[cpc_pkg::CNT_BITS-1:0], 1'b1};
      end else begin
         div_step = {t[cpc_pkg::CNT_BITS-1:0], 1'b0};
      end
   endfunction

   logic [1:0] state_ff, state_in;
   logic [cpc_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [cpc_pkg::SUM_BITS-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [cpc_pkg::CNT_BITS-1:0]  rx_ff, rx_in, ry_ff, ry_in, n_ff, n_in;
   logic                          ovf_ff, ovf_in, done_ff, done_in, last_ff, last_in;

   logic                           out_valid_ff, out_valid_in;
   logic [cpc_pkg::COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [cpc_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                           o_ovf_ff, o_ovf_in, o_done_ff, o_done_in;
   logic                           o_last_ff, o_last_in;

   logic [cpc_pkg::CNT_BITS:0] sx, sy;
   logic [cpc_pkg::CNT_BITS:0] twice_rx, twice_ry, n_ext;
   logic                       up_x, up_y, out_free;
   logic [cpc_pkg::SUM_BITS-1:0] rounded_x, rounded_y;

   assign pop_ready = (state_ff == B_IDLE);
   assign out_free  = !out_valid_ff || rsp_bus.ready;

   assign sx = div_step(rx_ff, qx_ff[cpc_pkg::SUM_BITS-1], n_ff);
   assign sy = div_step(ry_ff, qy_ff[cpc_pkg::SUM_BITS-1], n_ff);

   // round half to even
   assign twice_rx  = {rx_ff, 1'b0};
   assign twice_ry  = {ry_ff, 1'b0};
   assign n_ext     = {1'b0, n_ff};
   assign up_x      = (twice_rx > n_ext) || ((twice_rx == n_ext) && qx_ff[0]);
   assign up_y      = (twice_ry > n_ext) || ((twice_ry == n_ext) && qy_ff[0]);
   assign rounded_x = qx_ff + cpc_pkg::SUM_BITS'(up_x);
   assign rounded_y = qy_ff + cpc_pkg::SUM_BITS'(up_y);

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.center_x       = cx_ff;
   assign rsp_bus.center_y       = cy_ff;
   assign rsp_bus.member_count   = cnt_ff;
   assign rsp_bus.count_overflow = o_ovf_ff;
   assign rsp_bus.hull_done      = o_done_ff;
   assign rsp_bus.run_last       = o_last_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cnt_in       = cnt_ff;
      o_ovf_in     = o_ovf_ff;
      o_done_in    = o_done_ff;
      o_last_in    = o_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               qx_in    = pop_job.sum_x;
               qy_in    = pop_job.sum_y;
               rx_in    = '0;
               ry_in    = '0;
               n_in     = pop_job.count;
               ovf_in   = pop_job.overflow;
               done_in  = pop_job.hull_done;
               last_in  = pop_job.run_last;
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            qx_in   = {qx_ff[cpc_pkg::SUM_BITS-2:0], sx[0]};
            qy_in   = {qy_ff[cpc_pkg::SUM_BITS-2:0], sy[0]};
            rx_in   = sx[cpc_pkg::CNT_BITS:1];
            ry_in   = sy[cpc_pkg::CNT_BITS:1];
            step_in = step_ff + 1'b1;
            if (step_ff == cpc_pkg::STEP_BITS'(cpc_pkg::SUM_BITS - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               cx_in        = rounded_x[cpc_pkg::COORD_BITS-1:0];
               cy_in        = rounded_y[cpc_pkg::COORD_BITS-1:0];
               cnt_in       = n_ff;
               o_ovf_in     = ovf_ff;
               o_done_in    = done_ff;
               o_last_in    = last_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      n_ff      <= n_in;
      ovf_ff    <= ovf_in;
      done_ff   <= done_in;
      last_ff   <= last_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cnt_ff    <= cnt_in;
      o_ovf_ff  <= o_ovf_in;
      o_done_ff <= o_done_in;
      o_last_ff <= o_last_in;
   end

endmodule

@@ design/consecutive_point_clusterer_top.sv @@
`timescale 1ns / 1ps
// Consecutive point clusterer: groups the points of a hull into runs of near
// neighbours and gives each run's rounded centroid and member count.
// req_bus  : one hull point per word (x, y, first/last marks).
// rsp_bus  : zero, one or two words per point; run_last marks the final one.
// csr_bus  : register 0 join distance squared, register 1 minimum cluster size;
//            always ready; the user must write them only while the block
//            is idle, which the block itself does not enforce.
// Path     : a point goes through the front's DIST, EVAL and PUSH states,
//            the queue, the divider over all 24 quotient bits and rounding.
// The front takes no new point until its words are pushed; each emitted
// cluster holds the shared divider until its word is taken into the output.
// A 4-deep queue between front and divider, and a registered output, let
// points keep coming while rsp_bus is stalled; once the queue is full the
// front holds off req_bus.ready.
// Reset: synchronous, active high; no cluster is open, registers return to
// join distance 0 and minimum size 1, queue and output are emptied.
module consecutive_point_clusterer_top (
   input logic        clock,
   input logic        reset,
   cpc_req_if.sink    req_bus,
   cpc_rsp_if.source  rsp_bus,
   cpc_csr_if.sink    csr_bus
);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   cpc_pkg::job_type push_job, pop_job;

   cpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   cpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   cpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ design/cpc_checker.sv @@
`timescale 1ns / 1ps
module cpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cpc_pkg::COORD_BITS-1:0] center_x,
   input logic [cpc_pkg::CNT_BITS-1:0]   member_count,
   input logic                           count_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(center_x))
      else $error("rsp word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> member_count != '0)
      else $error("cluster with no members");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_overflow |->
         member_count == cpc_pkg::CNT_BITS'(cpc_pkg::MAX_POINTS))
      else $error("overflow flagged below the count bound");

endmodule

bind consecutive_point_clusterer_top cpc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .center_x       (rsp_bus.center_x),
   .member_count   (rsp_bus.member_count),
   .count_overflow (rsp_bus.count_overflow)
);
